// ===== rtl/core/nps_pkg.sv =====
package nps_pkg;

  // Field widths of one job and of one result
  localparam int unsigned ID_W    = 16;
  localparam int unsigned ARR_W   = 16;
  localparam int unsigned BURST_W = 16;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned TIME_W  = 23;

  // One stored job, as held in the job memory
  typedef struct packed {
    logic [ID_W-1:0]    job_id;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } job_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // store the input job (input transfer)
    logic run_start;  // begin a schedule run: clear clock and dispatch count
    logic scan;       // start a selection scan over the stored jobs
    logic commit;     // dispatch the selected job into the output register
  } nps_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_done;  // last memory word of the scan is in the read register
    logic out_free;   // output register can take a new result this cycle
    logic last_disp;  // the pending dispatch is the final one of the run
  } nps_sts_t;

endpackage

// ===== rtl/core/nps_datapath.sv =====
module nps_datapath #(
  parameter int unsigned MAX_PROCS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  nps_pkg::nps_cmd_t           cmd_i,
  output nps_pkg::nps_sts_t           sts_o,
  input  logic [nps_pkg::ID_W-1:0]    job_id_i,
  input  logic [nps_pkg::ARR_W-1:0]   arrival_i,
  input  logic [nps_pkg::BURST_W-1:0] burst_i,
  input  logic [nps_pkg::PRIO_W-1:0]  prio_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [nps_pkg::ID_W-1:0]    out_job_id_o,
  output logic [nps_pkg::TIME_W-1:0]  completion_o,
  output logic [nps_pkg::TIME_W-1:0]  turnaround_o,
  output logic [nps_pkg::TIME_W-1:0]  waiting_o,
  output logic                        last_result_o
);
  import nps_pkg::*;

  localparam int unsigned IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);

  // Job memory: one write port (load), one registered read port (scan)
  job_t job_mem [MAX_PROCS];

  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     disp_q;
  logic [IDX_W-1:0]     scan_idx_q;
  logic                 scan_act_q;
  logic                 rd_vld_q;
  logic                 rd_last_q;
  logic [IDX_W-1:0]     rd_idx_q;
  logic                 rd_fin_q;
  job_t                 rd_q;
  logic [MAX_PROCS-1:0] fin_q;
  logic [TIME_W-1:0]    clock_q;

  // Best ready job, and best job among the earliest pending arrivals
  logic                 rfound_q;
  job_t                 r_job_q;
  logic [IDX_W-1:0]     r_idx_q;
  logic                 mfound_q;
  job_t                 m_job_q;
  logic [IDX_W-1:0]     m_idx_q;

  logic                 out_valid_q;
  logic [ID_W-1:0]      out_id_q;
  logic [TIME_W-1:0]    compl_q;
  logic [TIME_W-1:0]    tat_q;
  logic [TIME_W-1:0]    wait_q;
  logic                 out_last_q;

  logic                 has_room;
  logic                 scan_end;
  logic                 last_disp;
  logic                 take_r;
  logic                 take_m;
  job_t                 sel_job;
  logic [IDX_W-1:0]     sel_idx;
  logic [TIME_W-1:0]    start_time;
  logic [TIME_W-1:0]    done_time;
  logic [TIME_W-1:0]    sel_arr;

  assign has_room  = count_q < CNT_W'(MAX_PROCS);
  assign scan_end  = CNT_W'(scan_idx_q) == (count_q - CNT_W'(1));
  assign last_disp = (disp_q + CNT_W'(1)) == count_q;

  // Candidate updates for the word leaving the read register
  assign take_r = !rd_fin_q && (TIME_W'(rd_q.arrival) <= clock_q) &&
                  (!rfound_q || (rd_q.prio > r_job_q.prio) ||
                   ((rd_q.prio == r_job_q.prio) && (rd_q.arrival < r_job_q.arrival)));
  assign take_m = !rd_fin_q &&
                  (!mfound_q || (rd_q.arrival < m_job_q.arrival) ||
                   ((rd_q.arrival == m_job_q.arrival) && (rd_q.prio > m_job_q.prio)));

  // Pick the ready job, or jump the clock to the earliest pending arrival
  always_comb begin
    if (rfound_q) begin
      sel_job    = r_job_q;
      sel_idx    = r_idx_q;
      start_time = clock_q;
    end else begin
      sel_job    = m_job_q;
      sel_idx    = m_idx_q;
      start_time = TIME_W'(m_job_q.arrival);
    end
  end

  assign sel_arr   = TIME_W'(sel_job.arrival);
  assign done_time = start_time + TIME_W'(sel_job.burst);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      disp_q      <= '0;
      scan_idx_q  <= '0;
      scan_act_q  <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      fin_q       <= '0;
      clock_q     <= '0;
      rfound_q    <= 1'b0;
      mfound_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // Advance the scan address
      if (cmd_i.scan) begin
        scan_act_q <= 1'b1;
        scan_idx_q <= '0;
      end else if (scan_act_q) begin
        if (scan_end) begin
          scan_act_q <= 1'b0;
        end
        scan_idx_q <= scan_idx_q + IDX_W'(1);
      end
      rd_vld_q  <= scan_act_q;
      rd_last_q <= scan_act_q & scan_end;

      // Track candidate validity
      if (cmd_i.scan) begin
        rfound_q <= 1'b0;
        mfound_q <= 1'b0;
      end else if (rd_vld_q) begin
        if (take_r) begin
          rfound_q <= 1'b1;
        end
        if (take_m) begin
          mfound_q <= 1'b1;
        end
      end

      // Dispatch: mark finished, advance clock, drop the batch at the end
      if (cmd_i.commit) begin
        clock_q <= done_time;
        if (last_disp) begin
          count_q <= '0;
          fin_q   <= '0;
          disp_q  <= '0;
        end else begin
          fin_q[sel_idx] <= 1'b1;
          disp_q         <= disp_q + CNT_W'(1);
        end
      end else if (cmd_i.run_start) begin
        clock_q <= '0;
        disp_q  <= '0;
        if (has_room) begin
          count_q <= count_q + CNT_W'(1);
        end
      end else if (cmd_i.load && has_room) begin
        count_q <= count_q + CNT_W'(1);
      end

      // Hold the result until the output transfer
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Job memory write
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && has_room) begin
      job_mem[count_q[IDX_W-1:0]] <= '{job_id:  job_id_i,
                                       arrival: arrival_i,
                                       burst:   burst_i,
                                       prio:    prio_i};
    end
  end

  // Registered read and payload registers
  always_ff @(posedge clk_i) begin
    rd_q     <= job_mem[scan_idx_q];
    rd_idx_q <= scan_idx_q;
    rd_fin_q <= fin_q[scan_idx_q];
    if (rd_vld_q && take_r) begin
      r_job_q <= rd_q;
      r_idx_q <= rd_idx_q;
    end
    if (rd_vld_q && take_m) begin
      m_job_q <= rd_q;
      m_idx_q <= rd_idx_q;
    end
    if (cmd_i.commit) begin
      out_id_q   <= sel_job.job_id;
      compl_q    <= done_time;
      tat_q      <= done_time - sel_arr;
      wait_q     <= start_time - sel_arr;
      out_last_q <= last_disp;
    end
  end

  assign sts_o.scan_done = rd_vld_q & rd_last_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.last_disp = last_disp;

  assign out_valid_o   = out_valid_q;
  assign out_job_id_o  = out_id_q;
  assign completion_o  = compl_q;
  assign turnaround_o  = tat_q;
  assign waiting_o     = wait_q;
  assign last_result_o = out_last_q;

endmodule

// ===== rtl/core/nps_ctrl.sv =====
module nps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_i,
  output logic              in_ready_o,
  output nps_pkg::nps_cmd_t cmd_o,
  input  nps_pkg::nps_sts_t sts_i
);
  import nps_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   in_xfer;
  logic   commit;

  assign in_xfer = in_valid_i & in_ready_q;
  assign commit  = (state_q == ST_PICK) & sts_i.out_free;

  // Commands decoded from state and handshakes
  assign cmd_o.load      = in_xfer;
  assign cmd_o.run_start = in_xfer & last_i;
  assign cmd_o.scan      = (in_xfer & last_i) | (commit & !sts_i.last_disp);
  assign cmd_o.commit    = commit;

  assign in_ready_o = in_ready_q;

  // Sequence load, scan and dispatch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_xfer && last_i) begin
            state_q    <= ST_SCAN;
            in_ready_q <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (sts_i.scan_done) begin
            state_q <= ST_PICK;
          end
        end
        ST_PICK: begin
          if (commit) begin
            if (sts_i.last_disp) begin
              state_q    <= ST_IDLE;
              in_ready_q <= 1'b1;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        default: begin
          state_q    <= ST_IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/nonpreemptive_priority_scheduler.sv =====
// Non-preemptive priority scheduler.
// Input channel (in_valid_i / in_ready_o): one job per transfer, one per
// cycle while loading. Up to MAX_PROCS jobs are stored; further jobs are
// dropped. A transfer with last_i high closes the batch and starts a run.
// During a run the input is not ready. Each dispatch scans every stored
// job through the single read port of the job memory: the N reads of a
// batch of N jobs, the read register, then the dispatch; a run repeats
// this scan once for each job.
// Output channel (out_valid_o / out_ready_i): one result per dispatched job
// in dispatch order, last_result_o high on the final one. The result sits in
// an output register; while the receiver stalls, the block finishes the next
// scan and then holds until the register is taken. After the final result
// is handed to the output register the input is ready again, even if that
// result still waits.
// Reset empties the batch and the output register; job contents are not
// cleared and need not be, since only loaded entries are read.
module nonpreemptive_priority_scheduler #(
  parameter int unsigned MAX_PROCS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [nps_pkg::ID_W-1:0]    job_id_i,
  input  logic [nps_pkg::ARR_W-1:0]   arrival_i,
  input  logic [nps_pkg::BURST_W-1:0] burst_i,
  input  logic [nps_pkg::PRIO_W-1:0]  prio_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [nps_pkg::ID_W-1:0]    out_job_id_o,
  output logic [nps_pkg::TIME_W-1:0]  completion_o,
  output logic [nps_pkg::TIME_W-1:0]  turnaround_o,
  output logic [nps_pkg::TIME_W-1:0]  waiting_o,
  output logic                        last_result_o
);
  import nps_pkg::*;

  nps_cmd_t cmd;
  nps_sts_t sts;

  // Sequencer
  nps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Job store, selection scan and result computation
  nps_datapath #(
    .MAX_PROCS (MAX_PROCS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .job_id_i      (job_id_i),
    .arrival_i     (arrival_i),
    .burst_i       (burst_i),
    .prio_i        (prio_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .out_job_id_o  (out_job_id_o),
    .completion_o  (completion_o),
    .turnaround_o  (turnaround_o),
    .waiting_o     (waiting_o),
    .last_result_o (last_result_o)
  );

endmodule
